### design/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg - banked register file package
// command codes, mode codes, payload types and bank lookup functions
// ----------------------------------------------------------------------------
package brf_pkg;

   // command codes
   localparam logic [3:0] CMD_READ       = 4'd0;
   localparam logic [3:0] CMD_READ_MODE  = 4'd1;
   localparam logic [3:0] CMD_WRITE      = 4'd2;
   localparam logic [3:0] CMD_WRITE_MODE = 4'd3;
   localparam logic [3:0] CMD_WRITE_SAVED = 4'd4;
   localparam logic [3:0] CMD_READ_SAVED = 4'd5;
   localparam logic [3:0] CMD_SAVE       = 4'd6;
   localparam logic [3:0] CMD_RESTORE    = 4'd7;
   localparam logic [3:0] CMD_WRITE_STATUS = 4'd8;

   // processor mode codes
   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1B;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   localparam int THUMB_BIT = 5;

   localparam logic [3:0] REG_SP = 4'd13;
   localparam logic [3:0] REG_LR = 4'd14;
   localparam logic [3:0] REG_PC = 4'd15;

   localparam logic [31:0] PC_MASK_ARM   = 32'hFFFF_FFFC;
   localparam logic [31:0] PC_MASK_THUMB = 32'hFFFF_FFFE;
   localparam logic [31:0] RESET_SP      = 32'h0300_7F00;
   localparam logic [31:0] RESET_LR      = 32'h0800_0000;
   localparam logic [31:0] RESET_PC      = 32'h0800_0000;
   localparam logic [31:0] RESET_STATUS  = 32'h2000_001F;

   // storage groups
   localparam logic [1:0] GRP_SHARED = 2'd0;
   localparam logic [1:0] GRP_FIQ    = 2'd1;
   localparam logic [1:0] GRP_SL     = 2'd2;

   typedef struct packed {
      logic [3:0]  command;
      logic [3:0]  reg_index;
      logic [4:0]  mode_sel;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] status_value;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] group;
      logic [3:0] index;
   } loc_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] slot;
   } slot_type;

   // saved status slot of a mode
   function automatic slot_type saved_slot(input logic [4:0] mode);
      slot_type s;
      s = '{valid: 1'b1, slot: 3'd0};
      unique case (mode)
         MODE_FIQ: s.slot = 3'd0;
         MODE_SVC: s.slot = 3'd1;
         MODE_ABT: s.slot = 3'd2;
         MODE_IRQ: s.slot = 3'd3;
         MODE_UND: s.slot = 3'd4;
         default:  s.valid = 1'b0;
      endcase
      return s;
   endfunction

   // storage cell of register idx as seen in a mode
   function automatic loc_type locate(input logic [3:0] idx, input logic [4:0] mode);
      loc_type    l;
      logic [1:0] bank;
      logic       banked;
      l      = '{valid: 1'b1, group: GRP_SHARED, index: idx};
      bank   = 2'd0;
      banked = 1'b0;
      unique case (mode)
         MODE_USR, MODE_SYS: banked = 1'b0;
         MODE_FIQ: begin
            if (idx >= 4'd8 && idx <= 4'd14) begin
               l.group = GRP_FIQ;
               l.index = idx - 4'd8;
            end
         end
         MODE_SVC: begin bank = 2'd0; banked = 1'b1; end
         MODE_ABT: begin bank = 2'd1; banked = 1'b1; end
         MODE_IRQ: begin bank = 2'd2; banked = 1'b1; end
         MODE_UND: begin bank = 2'd3; banked = 1'b1; end
         default:  l.valid = 1'b0;
      endcase
      if (banked && (idx == REG_SP || idx == REG_LR)) begin
         l.group = GRP_SL;
         l.index = {1'b0, bank, (idx == REG_LR)};
      end
      return l;
   endfunction

endpackage

### design/brf_channels.sv
// ----------------------------------------------------------------------------
// brf channels - request and response handshake interfaces
// valid/ready channels carrying the request and response payloads
// ----------------------------------------------------------------------------
interface brf_req_if;
   logic              valid;
   logic              ready;
   brf_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface brf_rsp_if;
   logic              valid;
   logic              ready;
   brf_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/brf_regs.sv
// ----------------------------------------------------------------------------
// brf_regs - banked register storage
// shared, fast-interrupt and stack/link banks, saved and current status
// ----------------------------------------------------------------------------
module brf_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  brf_pkg::req_type req,
   output brf_pkg::rsp_type rsp
);
   import brf_pkg::*;

   logic [31:0] shared_ff [16];
   logic [31:0] fiq_ff    [7];
   logic [31:0] sl_ff     [8];
   logic [31:0] saved_ff  [5];
   logic [31:0] status_ff;
   logic [31:0] status_in;

   logic [4:0]  cur_mode;
   logic [4:0]  acc_mode;
   slot_type    cur_slot;
   loc_type     loc;
   logic [31:0] reg_rd;
   logic [31:0] wr_value;
   logic        reg_we;
   logic        saved_we;
   logic [31:0] saved_wd;
   logic [31:0] saved_rd;

   always_comb begin
      cur_mode = status_ff[4:0];
      cur_slot = saved_slot(cur_mode);
      acc_mode = (req.command == CMD_READ_MODE || req.command == CMD_WRITE_MODE)
                 ? req.mode_sel : cur_mode;
      loc = locate(req.reg_index, acc_mode);

      case (loc.group)
         GRP_FIQ: reg_rd = fiq_ff[loc.index[2:0]];
         GRP_SL:  reg_rd = sl_ff[loc.index[2:0]];
         default: reg_rd = shared_ff[loc.index];
      endcase
      if (!loc.valid) reg_rd = '0;

      saved_rd = cur_slot.valid ? saved_ff[cur_slot.slot] : status_ff;

      // pc alignment follows the current state even for other-mode writes
      wr_value = req.write_value;
      if (req.reg_index == REG_PC)
         wr_value = req.write_value &
                    (status_ff[THUMB_BIT] ? PC_MASK_THUMB : PC_MASK_ARM);

      reg_we    = 1'b0;
      saved_we  = 1'b0;
      saved_wd  = req.write_value;
      status_in = status_ff;
      rsp.read_data = '0;
      unique case (req.command)
         CMD_READ, CMD_READ_MODE: rsp.read_data = reg_rd;
         CMD_WRITE, CMD_WRITE_MODE: reg_we = loc.valid;
         CMD_WRITE_SAVED: saved_we = cur_slot.valid;
         CMD_READ_SAVED: rsp.read_data = saved_rd;
         CMD_SAVE: begin
            saved_we = cur_slot.valid;
            saved_wd = status_ff;
         end
         CMD_RESTORE: if (cur_slot.valid) status_in = saved_ff[cur_slot.slot];
         CMD_WRITE_STATUS: status_in = req.write_value;
         default: ;
      endcase
      rsp.status_value = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) shared_ff[i] <= '0;
         shared_ff[13] <= RESET_SP;
         shared_ff[14] <= RESET_LR;
         shared_ff[15] <= RESET_PC;
         for (int i = 0; i < 7; i++) fiq_ff[i] <= '0;
         for (int i = 0; i < 8; i++) sl_ff[i] <= '0;
         for (int i = 0; i < 5; i++) saved_ff[i] <= '0;
         status_ff <= RESET_STATUS;
      end else if (enable) begin
         if (reg_we) begin
            case (loc.group)
               GRP_FIQ: fiq_ff[loc.index[2:0]] <= wr_value;
               GRP_SL:  sl_ff[loc.index[2:0]]  <= wr_value;
               default: shared_ff[loc.index]   <= wr_value;
            endcase
         end
         if (saved_we) saved_ff[cur_slot.slot] <= saved_wd;
         status_ff <= status_in;
      end
   end

   // status changes only through restore or status write
   a_status_hold: assert property (@(posedge clock) disable iff (reset)
      enable && req.command != CMD_RESTORE && req.command != CMD_WRITE_STATUS
      |=> $stable(status_ff))
      else $error("status changed by a non-status command");

   // an aligned pc write leaves the low bit clear
   a_pc_align: assert property (@(posedge clock) disable iff (reset)
      enable && reg_we && loc.group == GRP_SHARED && loc.index == REG_PC
      |=> shared_ff[15][0] == 1'b0)
      else $error("unaligned pc stored");

   // write commands return zero read data
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (req.command == CMD_WRITE || req.command == CMD_WRITE_MODE ||
       req.command == CMD_SAVE || req.command == CMD_RESTORE)
      |-> rsp.read_data == '0)
      else $error("write command returned data");

endmodule

### design/banked_register_file_top.sv
// ----------------------------------------------------------------------------
// banked_register_file_top - mode-banked register file
// one register, saved status or status command per request
// ----------------------------------------------------------------------------
// usage
//   req_ch   request channel: command, reg_index, mode_sel, write_value
//   rsp_ch   response channel: read_data and the status word after the command
//   every request gives exactly one response, in request order
// timing
//   a request is captured in the input register, executed against the banks
//   once the output register is free, and its response lands in the output
//   register; throughput is one request per cycle while rsp_ch.ready stays
//   high; state updates happen at the same
//   edge the response is registered, so back-to-back requests see each
//   other's writes
// reset
//   synchronous, active high: banks take their power-on values, the status
//   word reads system mode in arm state with carry set, both stages empty
// stall
//   while the response is not taken the input register holds its request
//   and req_ch.ready drops once it is full; nothing is lost or repeated
// ----------------------------------------------------------------------------
module banked_register_file_top (
   input  logic      clock,
   input  logic      reset,
   brf_req_if.sink   req_ch,
   brf_rsp_if.source rsp_ch
);
   import brf_pkg::*;

   // input stage
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_req_ff;

   // output stage
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type exec_rsp;

   logic    advance;
   logic    execute;
   logic    take;

   // the output register frees up when empty or being drained
   assign advance = !out_valid_ff || rsp_ch.ready;
   assign execute = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = execute || (out_valid_ff && !rsp_ch.ready);

   brf_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .enable (execute),
      .req    (in_req_ff),
      .rsp    (exec_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (take) in_req_ff <= req_ch.payload;
      if (execute) out_rsp_ff <= exec_rsp;
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_rsp_ff;

   // an executed request always shows up as a response next cycle
   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      execute |=> out_valid_ff)
      else $error("executed request lost");

   // a stalled response is not overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(out_rsp_ff))
      else $error("stalled response overwritten");

   // a waiting request is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_req_ff))
      else $error("pending request dropped");

endmodule

### sim/tb_banked_register_file_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_banked_register_file_top - banked register file regression
// directed requests and ~750 random requests against a built-in model of the
// banked register set, with random idling on both channels, one long response
// stall, and in-order field checks of every response
// ----------------------------------------------------------------------------
module tb_banked_register_file_top;
   import brf_pkg::*;

   // spare command codes, the block leaves state alone for these
   localparam logic [3:0] CMD_SPARE_LO = 4'd9;
   localparam logic [3:0] CMD_SPARE_HI = 4'd15;

   // first register that fast-interrupt mode banks
   localparam logic [3:0] REG_FIQ_FIRST = 4'd8;

   // flat model storage: shared r0..r15, then fiq r8..r14, then sp/lr pairs
   localparam int FIQ_BASE  = 16;
   localparam int SL_BASE   = 23;
   localparam int CELL_LAST = 30;
   localparam int SPSR_LAST = 4;

   localparam int RANDOM_REQS  = 750;
   localparam int HOLD_AT      = 400;   // accepted requests before the long stall
   localparam int HOLD_CYCLES  = 300;
   localparam int CALM_FROM    = 150;   // window with no idling on either side
   localparam int CALM_TO      = 260;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   brf_req_if req_ch ();
   brf_rsp_if rsp_ch ();

   banked_register_file_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // model state
   logic [31:0] gpr_model  [0:CELL_LAST];
   logic [31:0] spsr_model [0:SPSR_LAST];
   logic [31:0] cpsr_model;

   req_type pending_reqs  [$];
   rsp_type expected_rsps [$];

   int error_count   = 0;
   int reqs_accepted = 0;
   int idle_cycles   = 0;
   int req_gap_left  = 0;
   int rsp_stall_left = 0;
   int rsp_hold_left = 0;
   bit rsp_hold_done = 1'b0;
   bit req_taken     = 1'b0;

   // clock, 2 ns period
   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // model of the banked register set
   // ---------------------------------------------------------------------

   task automatic reset_model();
      for (int i = 0; i <= CELL_LAST; i++) gpr_model[i] = '0;
      for (int i = 0; i <= SPSR_LAST; i++) spsr_model[i] = '0;
      gpr_model[REG_SP] = RESET_SP;
      gpr_model[REG_LR] = RESET_LR;
      gpr_model[REG_PC] = RESET_PC;
      cpsr_model        = RESET_STATUS;
   endtask

   // saved status slot of a mode, -1 for user, system and invalid modes
   function automatic int spsr_slot(input logic [4:0] mode);
      case (mode)
         MODE_FIQ: return 0;
         MODE_SVC: return 1;
         MODE_ABT: return 2;
         MODE_IRQ: return 3;
         MODE_UND: return 4;
         default:  return -1;
      endcase
   endfunction

   // model entry that register idx maps to in a mode, -1 for an invalid mode
   function automatic int gpr_cell(input logic [3:0] idx, input logic [4:0] mode);
      int pair;
      pair = 0;
      case (mode)
         MODE_USR, MODE_SYS: return int'(idx);
         MODE_FIQ: begin
            if (idx >= REG_FIQ_FIRST && idx <= REG_LR)
               return FIQ_BASE + int'(idx) - int'(REG_FIQ_FIRST);
            return int'(idx);
         end
         MODE_SVC: pair = 0;
         MODE_ABT: pair = 1;
         MODE_IRQ: pair = 2;
         MODE_UND: pair = 3;
         default:  return -1;
      endcase
      if (idx == REG_SP || idx == REG_LR)
         return SL_BASE + 2 * pair + ((idx == REG_LR) ? 1 : 0);
      return int'(idx);
   endfunction

   function automatic logic [31:0] read_gpr(input logic [3:0] idx, input logic [4:0] mode);
      int entry;
      entry = gpr_cell(idx, mode);
      return (entry < 0) ? 32'h0 : gpr_model[entry];
   endfunction

   // pc writes are aligned by the current thumb bit, whatever mode is named
   function automatic void write_gpr(input logic [3:0] idx, input logic [4:0] mode,
                                     input logic [31:0] value);
      int          entry;
      logic [31:0] data;
      data = value;
      if (idx == REG_PC)
         data &= cpsr_model[THUMB_BIT] ? PC_MASK_THUMB : PC_MASK_ARM;
      entry = gpr_cell(idx, mode);
      if (entry >= 0) gpr_model[entry] = data;
   endfunction

   // applies one request to the model and returns the response it gives
   function automatic rsp_type predict_response(input req_type r);
      rsp_type     res;
      logic [4:0]  cur_mode;
      int          slot;
      cur_mode      = cpsr_model[4:0];
      slot          = spsr_slot(cur_mode);
      res.read_data = 32'h0;
      case (r.command)
         CMD_READ:       res.read_data = read_gpr(r.reg_index, cur_mode);
         CMD_READ_MODE:  res.read_data = read_gpr(r.reg_index, r.mode_sel);
         CMD_WRITE:      write_gpr(r.reg_index, cur_mode, r.write_value);
         CMD_WRITE_MODE: write_gpr(r.reg_index, r.mode_sel, r.write_value);
         CMD_WRITE_SAVED: if (slot >= 0) spsr_model[slot] = r.write_value;
         CMD_READ_SAVED: res.read_data = (slot >= 0) ? spsr_model[slot] : cpsr_model;
         CMD_SAVE:       if (slot >= 0) spsr_model[slot] = cpsr_model;
         CMD_RESTORE:    if (slot >= 0) cpsr_model = spsr_model[slot];
         CMD_WRITE_STATUS: cpsr_model = r.write_value;
         default: ;
      endcase
      res.status_value = cpsr_model;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   task automatic queue_req(input logic [3:0] cmd, input logic [3:0] idx,
                            input logic [4:0] msel, input logic [31:0] value);
      req_type r;
      r.command     = cmd;
      r.reg_index   = idx;
      r.mode_sel    = msel;
      r.write_value = value;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [4:0] pick_mode();
      case ($urandom_range(0, 6))
         0:       return MODE_USR;
         1:       return MODE_FIQ;
         2:       return MODE_IRQ;
         3:       return MODE_SVC;
         4:       return MODE_ABT;
         5:       return MODE_UND;
         default: return MODE_SYS;
      endcase
   endfunction

   // status word with random flags, random thumb bit and mostly a valid mode
   function automatic logic [31:0] pick_status();
      logic [31:0] word;
      word    = $urandom;
      word[4:0] = ($urandom_range(0, 9) != 0) ? pick_mode() : 5'($urandom_range(0, 31));
      return word;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      pick          = $urandom_range(0, 99);
      r.reg_index   = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(8, 15))
                                                  : 4'($urandom_range(0, 15));
      r.mode_sel    = ($urandom_range(0, 4) != 0) ? pick_mode() : 5'($urandom_range(0, 31));
      r.write_value = $urandom;
      if      (pick < 22) r.command = CMD_READ;
      else if (pick < 34) r.command = CMD_READ_MODE;
      else if (pick < 56) r.command = CMD_WRITE;
      else if (pick < 68) r.command = CMD_WRITE_MODE;
      else if (pick < 74) r.command = CMD_WRITE_SAVED;
      else if (pick < 80) r.command = CMD_READ_SAVED;
      else if (pick < 85) r.command = CMD_SAVE;
      else if (pick < 88) r.command = CMD_RESTORE;
      else if (pick < 96) r.command = CMD_WRITE_STATUS;
      else r.command = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      // saved and current status writes mostly carry a sane mode field
      if (r.command == CMD_WRITE_STATUS ||
          (r.command == CMD_WRITE_SAVED && $urandom_range(0, 3) != 0))
         r.write_value = pick_status();
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int pick;
      if (reqs_accepted >= CALM_FROM && reqs_accepted < CALM_TO) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ---------------------------------------------------------------------
   // request driver, changes at the falling edge
   // ---------------------------------------------------------------------
   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         // slot is free: idle for a while or offer the next request
         if (req_gap_left != 0) begin
            req_gap_left <= req_gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_ch.payload <= pending_reqs.pop_front();
            req_ch.valid   <= 1'b1;
            // keep offering back to back while the response side is held off
            req_gap_left   <= (rsp_hold_left != 0) ? 0 : pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // response ready, changes at the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         // long hold-off so the block fills up and drops req ready
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ch.ready  <= 1'b0;
      end else if (!rsp_hold_done && reqs_accepted >= HOLD_AT) begin
         rsp_hold_done <= 1'b1;
         rsp_hold_left <= HOLD_CYCLES;
         rsp_ch.ready  <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ch.ready   <= 1'b0;
      end else begin
         rsp_ch.ready   <= 1'b1;
         rsp_stall_left <= pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // monitor, samples at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         req_taken <= req_ch.valid && req_ch.ready;
         // check the response first so a request taken at this edge cannot mask it
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request waiting: read_data %h status_value %h",
                      rsp_ch.payload.read_data, rsp_ch.payload.status_value);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.payload.read_data !== want.read_data) begin
                  $error("read_data mismatch: expected %h, actual %h",
                         want.read_data, rsp_ch.payload.read_data);
                  error_count++;
               end
               if (rsp_ch.payload.status_value !== want.status_value) begin
                  $error("status_value mismatch: expected %h, actual %h",
                         want.status_value, rsp_ch.payload.status_value);
                  error_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(predict_response(req_ch.payload));
            reqs_accepted++;
         end
      end else begin
         req_taken <= 1'b0;
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("banked_register_file_top regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      reset_model();

      // power-on values of sp and lr in system mode
      queue_req(CMD_READ, REG_SP, MODE_SYS, 32'h0);
      queue_req(CMD_READ, REG_LR, MODE_SYS, 32'h0);
      // pc write in arm state drops the two low bits
      queue_req(CMD_WRITE, REG_PC, MODE_SYS, 32'hFFFF_FFFF);
      queue_req(CMD_READ, REG_PC, MODE_SYS, 32'h0);
      queue_req(CMD_WRITE, 4'd0, MODE_SYS, 32'hFFFF_FFFF);
      queue_req(CMD_READ, 4'd0, MODE_SYS, 32'h0);
      // thumb state: pc write drops bit 0 only
      queue_req(CMD_WRITE_STATUS, 4'd0, MODE_SYS, RESET_STATUS | (32'h1 << THUMB_BIT));
      queue_req(CMD_WRITE, REG_PC, MODE_SYS, 32'hFFFF_FFFF);
      // fast-interrupt bank of r8..r14
      queue_req(CMD_WRITE_STATUS, 4'd0, MODE_SYS, 32'hF000_0000 | 32'(MODE_FIQ));
      queue_req(CMD_WRITE, REG_FIQ_FIRST, MODE_SYS, 32'hA5A5_5A5A);
      queue_req(CMD_WRITE, REG_LR, MODE_SYS, 32'h1234_5678);
      queue_req(CMD_READ_MODE, REG_FIQ_FIRST, MODE_USR, 32'h0);
      queue_req(CMD_READ_MODE, REG_LR, MODE_FIQ, 32'h0);
      // saved status of the current mode
      queue_req(CMD_WRITE_SAVED, 4'd0, MODE_SYS, 32'hFFFF_FFFF);
      queue_req(CMD_READ_SAVED, 4'd0, MODE_SYS, 32'h0);
      queue_req(CMD_SAVE, 4'd0, MODE_SYS, 32'h0);
      queue_req(CMD_READ_SAVED, 4'd0, MODE_SYS, 32'h0);
      // supervisor mode, write into abort bank, invalid mode access
      queue_req(CMD_WRITE_STATUS, 4'd0, MODE_SYS, 32'h0000_0000 | 32'(MODE_SVC));
      queue_req(CMD_WRITE_MODE, REG_SP, MODE_ABT, 32'h8000_0001);
      queue_req(CMD_READ_MODE, REG_SP, MODE_ABT, 32'h0);
      queue_req(CMD_WRITE_MODE, REG_PC, MODE_UND, 32'h0000_0003);
      queue_req(CMD_WRITE_MODE, 4'd5, 5'd0, 32'hFFFF_FFFF);
      queue_req(CMD_READ_MODE, 4'd5, 5'd0, 32'h0);
      // restore of a zero saved word leaves an invalid current mode
      queue_req(CMD_RESTORE, 4'd0, MODE_SYS, 32'h0);
      queue_req(CMD_READ, 4'd0, MODE_SYS, 32'h0);
      queue_req(CMD_READ_SAVED, 4'd0, MODE_SYS, 32'h0);
      // user mode has no saved status, spare codes do nothing
      queue_req(CMD_WRITE_STATUS, 4'd0, MODE_SYS, 32'h2000_0000 | 32'(MODE_USR));
      queue_req(CMD_WRITE_SAVED, 4'd0, MODE_SYS, 32'h5555_5555);
      queue_req(CMD_READ_SAVED, 4'd0, MODE_SYS, 32'h0);
      queue_req(CMD_SPARE_LO, 4'd15, 5'd31, 32'hFFFF_FFFF);
      queue_req(CMD_SPARE_HI, 4'd0, 5'd0, 32'h0);

      for (int i = 0; i < RANDOM_REQS; i++) pending_reqs.push_back(random_req());

      // synchronous reset, released at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until every request is taken and every response checked
      while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
         @(posedge clock);
      // drain period to catch any stray response
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("banked_register_file_top regression: pass");
      else
         $display("banked_register_file_top regression: fail");
      $finish;
   end

endmodule
